FILE: src/pcpi_pkg.sv
// ----------------------------------------------------------------------------
// pcpi_pkg
// Shared types and constants of the positional/incremental PID core.
// ----------------------------------------------------------------------------
package pcpi_pkg;

    localparam int GAIN_W      = 16;
    localparam int LIMIT_W     = 15;
    localparam int ACC_W       = 48;
    // Widest coefficient is -kp - 2*kd, which needs two bits above a gain.
    localparam int COEF_W      = GAIN_W + 2;
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE       = 3'd0,
        CFG_PROP_GAIN  = 3'd1,
        CFG_INTEG_GAIN = 3'd2,
        CFG_DERIV_GAIN = 3'd3,
        CFG_OUT_MIN    = 3'd4,
        CFG_OUT_MAX    = 3'd5,
        CFG_INTEG_LIM  = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        MODE_POSITIONAL  = 1'b0,
        MODE_INCREMENTAL = 1'b1
    } t_mode;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
    } t_gains;

endpackage

FILE: src/pcpi_front.sv
// ----------------------------------------------------------------------------
// pcpi_front
// Accepts samples, forms the error, keeps the error history and computes the
// gain products and their sums in a three-stage pipeline feeding the queue.
// ----------------------------------------------------------------------------
module pcpi_front #(
    parameter int DATA_WIDTH = 16,
    parameter int PROD_W     = pcpi_pkg::COEF_W + DATA_WIDTH + 1,
    parameter int ENTRY_W    = 3 + (PROD_W + 1) + (PROD_W + 2)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [DATA_WIDTH-1:0]    i_setpoint,
    input  logic signed [DATA_WIDTH-1:0]    i_feedback,
    input  pcpi_pkg::t_mode                 i_mode,
    input  pcpi_pkg::t_gains                i_gains,
    input  logic [pcpi_pkg::QCNT_W-1:0]     i_q_count,
    output logic                            o_push,
    output logic [ENTRY_W-1:0]              o_entry
);

    localparam int ERR_W = DATA_WIDTH + 1;
    localparam int CW    = pcpi_pkg::COEF_W;
    localparam int OCC_W = pcpi_pkg::QCNT_W + 1;

    logic                   accept;
    logic signed [ERR_W-1:0] err;

    logic signed [ERR_W-1:0] r_ep, r_ep2;

    // Stage 1: error samples.
    logic                    r1_v;
    pcpi_pkg::t_mode         r1_mode;
    logic signed [ERR_W-1:0] r1_e, r1_ep, r1_ep2;

    // Stage 2: products.
    logic                     r2_v;
    pcpi_pkg::t_mode          r2_mode;
    logic                     r2_epos, r2_eneg;
    logic signed [PROD_W-1:0] r2_ma, r2_mb, r2_mc;

    // Stage 3: proportional/derivative term and accumulator increment.
    logic                       r3_v;
    pcpi_pkg::t_mode            r3_mode;
    logic                       r3_epos, r3_eneg;
    logic signed [PROD_W:0]     r3_pterm;
    logic signed [PROD_W+1:0]   r3_delta;

    logic signed [CW-1:0]     kp_x, ki_x, kd_x, c_a, c_b, c_c;
    logic signed [ERR_W-1:0]  x_c;
    logic signed [PROD_W-1:0] n_ma, n_mb, n_mc;
    logic signed [PROD_W:0]   sum_ab;
    logic [OCC_W-1:0]         occupancy;

    // Items in flight are counted against the queue so that the front never
    // has to stall once an item has entered it.
    assign occupancy = OCC_W'(i_q_count) + OCC_W'(r1_v) + OCC_W'(r2_v) + OCC_W'(r3_v);
    assign o_stall   = (occupancy >= OCC_W'(pcpi_pkg::QUEUE_DEPTH));
    assign accept    = i_valid && !o_stall;

    assign err = ERR_W'(i_setpoint) - ERR_W'(i_feedback);

    always_comb begin
        kp_x = CW'(i_gains.kp);
        ki_x = CW'(i_gains.ki);
        kd_x = CW'(i_gains.kd);
        if (r1_mode == pcpi_pkg::MODE_INCREMENTAL) begin
            c_a = kp_x + ki_x + kd_x;
            c_b = -kp_x - (kd_x <<< 1);
            c_c = kd_x;
            x_c = r1_ep2;
        end else begin
            c_a = kp_x + kd_x;
            c_b = -kd_x;
            c_c = ki_x;
            x_c = r1_e;
        end
        n_ma = PROD_W'(c_a) * PROD_W'(r1_e);
        n_mb = PROD_W'(c_b) * PROD_W'(r1_ep);
        n_mc = PROD_W'(c_c) * PROD_W'(x_c);
        sum_ab = (PROD_W + 1)'(r2_ma) + (PROD_W + 1)'(r2_mb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ep  <= '0;
            r_ep2 <= '0;
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
        end else begin
            r1_v <= accept;
            r2_v <= r1_v;
            r3_v <= r2_v;
            if (accept) begin
                r_ep  <= err;
                r_ep2 <= r_ep;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_mode <= i_mode;
            r1_e    <= err;
            r1_ep   <= r_ep;
            r1_ep2  <= r_ep2;
        end
        r2_mode <= r1_mode;
        r2_epos <= (r1_e > 0);
        r2_eneg <= (r1_e < 0);
        r2_ma   <= n_ma;
        r2_mb   <= n_mb;
        r2_mc   <= n_mc;
        r3_mode <= r2_mode;
        r3_epos <= r2_epos;
        r3_eneg <= r2_eneg;
        if (r2_mode == pcpi_pkg::MODE_INCREMENTAL) begin
            r3_pterm <= '0;
            r3_delta <= (PROD_W + 2)'(sum_ab) + (PROD_W + 2)'(r2_mc);
        end else begin
            r3_pterm <= sum_ab;
            r3_delta <= (PROD_W + 2)'(r2_mc);
        end
    end

    assign o_push  = r3_v;
    assign o_entry = {r3_mode, r3_epos, r3_eneg, r3_pterm, r3_delta};

endmodule

FILE: src/pcpi_queue.sv
// ----------------------------------------------------------------------------
// pcpi_queue
// Small first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module pcpi_queue #(
    parameter int WIDTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [WIDTH-1:0]              i_data,
    input  logic                          i_pop,
    output logic                          o_nonempty,
    output logic [WIDTH-1:0]              o_data,
    output logic [pcpi_pkg::QCNT_W-1:0]   o_count
);

    logic [WIDTH-1:0]              r_mem [pcpi_pkg::QUEUE_DEPTH];
    logic [pcpi_pkg::QPTR_W-1:0]   r_wptr, r_rptr;
    logic [pcpi_pkg::QCNT_W-1:0]   r_count;
    logic                          do_pop;

    assign o_nonempty = (r_count != '0);
    assign do_pop     = i_pop && o_nonempty;
    assign o_data     = r_mem[r_rptr];
    assign o_count    = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

FILE: src/pcpi_back.sv
// ----------------------------------------------------------------------------
// pcpi_back
// Updates the accumulator once per queued item and forms the clamped drive
// value in an output register that the downstream side may stall.
// ----------------------------------------------------------------------------
module pcpi_back #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8,
    parameter int PROD_W     = pcpi_pkg::COEF_W + DATA_WIDTH + 1,
    parameter int ENTRY_W    = 3 + (PROD_W + 1) + (PROD_W + 2)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_nonempty,
    input  logic [ENTRY_W-1:0]                i_q_data,
    output logic                              o_pop,
    input  logic signed [DATA_WIDTH-1:0]      i_out_min,
    input  logic signed [DATA_WIDTH-1:0]      i_out_max,
    input  logic [pcpi_pkg::LIMIT_W-1:0]      i_integ_limit,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [DATA_WIDTH-1:0]      o_drive
);

    localparam int ACC_W  = pcpi_pkg::ACC_W;
    localparam int WIDEST = (PROD_W + 2 > ACC_W) ? PROD_W + 2 : ACC_W;
    localparam int SUM_W  = WIDEST + 1;

    pcpi_pkg::t_mode          q_mode;
    logic                     q_mode_bit;
    logic                     q_epos, q_eneg;
    logic signed [PROD_W:0]   q_pterm;
    logic signed [PROD_W+1:0] q_delta;

    logic signed [ACC_W-1:0]  r_accum;
    logic signed [ACC_W-1:0]  n_accum;

    logic                     r_bv;
    pcpi_pkg::t_mode          r_bmode;
    logic signed [PROD_W:0]   r_bpterm;

    logic                     r_ov;
    logic signed [DATA_WIDTH-1:0] r_drive;

    logic                     out_load, b_adv;

    logic signed [SUM_W-1:0]  acc_x, nxt, lim, acc_hi, acc_lo, lo_s, hi_s;
    logic signed [SUM_W-1:0]  lo_x, hi_x, psum, pshift, yv;
    logic                     in_band, opposite;

    assign {q_mode_bit, q_epos, q_eneg, q_pterm, q_delta} = i_q_data;
    assign q_mode = pcpi_pkg::t_mode'(q_mode_bit);

    assign out_load = !r_ov || !i_stall;
    assign b_adv    = !r_bv || out_load;
    assign o_pop    = i_q_nonempty && b_adv;

    // Accumulator update for the item at the head of the queue.
    always_comb begin
        acc_x    = SUM_W'(r_accum);
        nxt      = acc_x + SUM_W'(q_delta);
        lim      = SUM_W'(i_integ_limit) <<< FRAC_BITS;
        acc_hi   = SUM_W'({1'b0, {(ACC_W - 1){1'b1}}});
        acc_lo   = -acc_hi - SUM_W'(1);
        lo_x     = SUM_W'(i_out_min);
        hi_x     = SUM_W'(i_out_max);
        lo_s     = lo_x <<< FRAC_BITS;
        hi_s     = hi_x <<< FRAC_BITS;
        in_band  = (-lim < acc_x) && (acc_x < lim);
        opposite = (acc_x < 0 && q_epos) || (acc_x > 0 && q_eneg);
        n_accum  = r_accum;
        if (q_mode == pcpi_pkg::MODE_INCREMENTAL) begin
            // If inverted, values above the lower bound get the upper bound.
            if (!(lo_s < nxt)) begin
                n_accum = ACC_W'(lo_s);
            end else if (nxt < hi_s) begin
                n_accum = ACC_W'(nxt);
            end else begin
                n_accum = ACC_W'(hi_s);
            end
        end else if (in_band || opposite) begin
            if (nxt > acc_hi) begin
                n_accum = ACC_W'(acc_hi);
            end else if (nxt < acc_lo) begin
                n_accum = ACC_W'(acc_lo);
            end else begin
                n_accum = ACC_W'(nxt);
            end
        end
    end

    // Drive value for the item held in the middle stage.
    always_comb begin
        psum   = SUM_W'(r_accum) + SUM_W'(r_bpterm);
        pshift = psum >>> FRAC_BITS;
        if (r_bmode == pcpi_pkg::MODE_INCREMENTAL) begin
            yv = SUM_W'(r_accum) >>> FRAC_BITS;
        end else if (!(lo_x < pshift)) begin
            yv = lo_x;
        end else if (pshift < hi_x) begin
            yv = pshift;
        end else begin
            yv = hi_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
            r_bv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_accum <= n_accum;
            end
            if (b_adv) begin
                r_bv <= i_q_nonempty;
            end
            if (out_load) begin
                r_ov <= r_bv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bmode  <= q_mode;
            r_bpterm <= q_pterm;
        end
        if (out_load && r_bv) begin
            r_drive <= DATA_WIDTH'(yv);
        end
    end

    assign o_valid = r_ov;
    assign o_drive = r_drive;

endmodule

FILE: src/pid_controller_pos_inc_core.sv
// ----------------------------------------------------------------------------
// pid_controller_pos_inc_core
// Fixed-point PID controller with positional and incremental modes.
// ----------------------------------------------------------------------------
//  Channel | Handshake                  | Payload
//  --------+----------------------------+---------------------------------
//  sample  | i_valid / o_stall          | i_setpoint, i_feedback
//  drive   | o_valid / i_stall          | o_drive
//  config  | i_cfg_valid / o_cfg_ready  | i_cfg_idx, i_cfg_data
//
// One sample is taken per cycle while o_stall is low. A sample passes through
// three front stages (error, products, sums), the queue, the accumulator stage
// and the output register. The accumulator stage updates once per item. Reset
// clears the accumulator, the error history and the pipeline. A stalled output
// fills the eight-entry queue; the sample side stalls once queued and in-flight
// items reach eight.
// ----------------------------------------------------------------------------
module pid_controller_pos_inc_core #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [DATA_WIDTH-1:0]          i_setpoint,
    input  logic signed [DATA_WIDTH-1:0]          i_feedback,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [DATA_WIDTH-1:0]          o_drive,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [pcpi_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [((DATA_WIDTH > pcpi_pkg::GAIN_W) ? DATA_WIDTH : pcpi_pkg::GAIN_W)-1:0]
                                                  i_cfg_data
);

    localparam int CFG_W   = (DATA_WIDTH > pcpi_pkg::GAIN_W) ? DATA_WIDTH : pcpi_pkg::GAIN_W;
    localparam int PROD_W  = pcpi_pkg::COEF_W + DATA_WIDTH + 1;
    localparam int ENTRY_W = 3 + (PROD_W + 1) + (PROD_W + 2);

    pcpi_pkg::t_mode                    r_mode;
    pcpi_pkg::t_gains                   r_gains;
    logic signed [DATA_WIDTH-1:0]       r_out_min, r_out_max;
    logic [pcpi_pkg::LIMIT_W-1:0]       r_integ_limit;
    logic                               cfg_wr;
    logic [CFG_W-1:0]                   cfg_data;

    logic                               q_push, q_pop, q_nonempty;
    logic [ENTRY_W-1:0]                 q_din, q_dout;
    logic [pcpi_pkg::QCNT_W-1:0]        q_count;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign cfg_data    = i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= pcpi_pkg::MODE_POSITIONAL;
            r_gains       <= '0;
            r_out_min     <= {1'b1, {(DATA_WIDTH - 1){1'b0}}};
            r_out_max     <= {1'b0, {(DATA_WIDTH - 1){1'b1}}};
            r_integ_limit <= '1;
        end else if (cfg_wr) begin
            case (i_cfg_idx)
                pcpi_pkg::CFG_MODE:       r_mode        <= pcpi_pkg::t_mode'(cfg_data[0]);
                pcpi_pkg::CFG_PROP_GAIN:  r_gains.kp    <= cfg_data[pcpi_pkg::GAIN_W-1:0];
                pcpi_pkg::CFG_INTEG_GAIN: r_gains.ki    <= cfg_data[pcpi_pkg::GAIN_W-1:0];
                pcpi_pkg::CFG_DERIV_GAIN: r_gains.kd    <= cfg_data[pcpi_pkg::GAIN_W-1:0];
                pcpi_pkg::CFG_OUT_MIN:    r_out_min     <= cfg_data[DATA_WIDTH-1:0];
                pcpi_pkg::CFG_OUT_MAX:    r_out_max     <= cfg_data[DATA_WIDTH-1:0];
                pcpi_pkg::CFG_INTEG_LIM:  r_integ_limit <= cfg_data[pcpi_pkg::LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pcpi_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .PROD_W     (PROD_W),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_setpoint (i_setpoint),
        .i_feedback (i_feedback),
        .i_mode     (r_mode),
        .i_gains    (r_gains),
        .i_q_count  (q_count),
        .o_push     (q_push),
        .o_entry    (q_din)
    );

    pcpi_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_data     (q_din),
        .i_pop      (q_pop),
        .o_nonempty (q_nonempty),
        .o_data     (q_dout),
        .o_count    (q_count)
    );

    pcpi_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .PROD_W     (PROD_W),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_nonempty  (q_nonempty),
        .i_q_data      (q_dout),
        .o_pop         (q_pop),
        .i_out_min     (r_out_min),
        .i_out_max     (r_out_max),
        .i_integ_limit (r_integ_limit),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_drive       (o_drive)
    );

endmodule
